/* hw/rtl/iss_pkg.sv */
package iss_pkg;

    // Field widths of the item and result channels.
    localparam int CMD_W  = 3;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 2;

    // Number of entries that a position can reach.
    localparam int POS_SPAN = 1 << POS_W;

    // Default depth of the sequence.
    localparam int CAPACITY_DEF = 16;

    // Command codes; the three unused codes fall to a default arm.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_FRONT = 3'd0,
        CMD_APPEND_BACK  = 3'd1,
        CMD_REMOVE_AT    = 3'd2,
        CMD_READ_AT      = 3'd3,
        CMD_WRITE_AT     = 3'd4
    } command_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_BAD_POS = 2'd2
    } status_t;

    // One command handed from the input stage to the store.
    typedef struct packed {
        logic                     fire;
        command_t                 op;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } iss_req_t;

    // One result returned by the store.
    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]         length;
        status_t                  status;
    } iss_rsp_t;

endpackage

/* hw/rtl/iss_store.sv */
module iss_store
    import iss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  iss_req_t req,
    output iss_rsp_t rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RD_N   = (CAPACITY < POS_SPAN) ? CAPACITY : POS_SPAN;

    logic signed [VAL_W-1:0] entries_reg [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_cmp;
    logic                    full;
    logic                    pos_ok;
    logic                    do_insert;
    logic                    do_append;
    logic                    do_remove;
    logic                    do_write;
    logic signed [VAL_W-1:0] read_view [POS_SPAN];

    // Range checks against the current fill.
    assign pos_ext = CMP_W'(req.position);
    assign cnt_cmp = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign pos_ok  = (pos_ext < cnt_cmp);

    // Decode the command into the update that it makes.
    always_comb
    begin
        do_insert      = 1'b0;
        do_append      = 1'b0;
        do_remove      = 1'b0;
        do_write       = 1'b0;
        count_next     = count_reg;
        rsp.read_value = '0;
        rsp.status     = STATUS_OK;
        unique case (req.op)
            CMD_INSERT_FRONT,
            CMD_APPEND_BACK:
            begin
                if (full)
                begin
                    rsp.status = STATUS_FULL;
                end
                else
                begin
                    do_insert  = (req.op == CMD_INSERT_FRONT);
                    do_append  = (req.op == CMD_APPEND_BACK);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE_AT:
            begin
                if (!pos_ok)
                begin
                    rsp.status = STATUS_BAD_POS;
                end
                else
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_READ_AT:
            begin
                if (!pos_ok)
                begin
                    rsp.status = STATUS_BAD_POS;
                end
                else
                begin
                    rsp.read_value = read_view[req.position];
                end
            end
            CMD_WRITE_AT:
            begin
                if (!pos_ok)
                begin
                    rsp.status = STATUS_BAD_POS;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        // The reported length is the new fill, cut to the field width.
        rsp.length = LEN_W'(count_next);
    end

    // Only the first entries can be reached by a position.
    for (genvar j = 0; j < POS_SPAN; j++)
    begin : g_view
        if (j < RD_N)
        begin : g_real
            assign read_view[j] = entries_reg[j];
        end
        else
        begin : g_none
            assign read_view[j] = '0;
        end
    end

    // Each entry takes its own value, a neighbor or the new value.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_entry
        localparam logic [CMP_W-1:0] K_IDX = CMP_W'(k);
        logic                    upd;
        logic signed [VAL_W-1:0] entry_next;

        always_comb
        begin
            upd        = 1'b0;
            entry_next = entries_reg[k];
            if (do_insert)
            begin
                upd        = 1'b1;
                entry_next = (k == 0) ? req.value : entries_reg[(k == 0) ? 0 : k - 1];
            end
            else if (do_append && (K_IDX == cnt_cmp))
            begin
                upd        = 1'b1;
                entry_next = req.value;
            end
            else if (do_remove && (K_IDX >= pos_ext) && (k < CAPACITY - 1))
            begin
                upd        = 1'b1;
                entry_next = entries_reg[(k < CAPACITY - 1) ? k + 1 : k];
            end
            else if (do_write && (K_IDX == pos_ext))
            begin
                upd        = 1'b1;
                entry_next = req.value;
            end
        end

        always_ff @(posedge clk)
        begin
            if (req.fire && upd)
            begin
                entries_reg[k] <= entry_next;
            end
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req.fire)
        begin
            count_reg <= count_next;
        end
    end

    // The fill never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A command that reports full leaves the fill as it was.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req.fire && (rsp.status == STATUS_FULL) |=> $stable(count_reg))
        else $error("fill changed on a full store");

    // A good removal shrinks the fill by one.
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        req.fire && (req.op == CMD_REMOVE_AT) && (rsp.status == STATUS_OK)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not shrink the fill");

    // Without a command the fill holds.
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !req.fire |=> $stable(count_reg))
        else $error("fill changed with no command");

endmodule

/* hw/rtl/indexed_sequence_store_unit.sv */
// Indexed sequence store: an ordered list of signed 32-bit values, empty
// after reset, up to CAPACITY entries deep.
// Input channel: command, position and value arrive with in_valid; an item
// is taken on a clock edge where in_valid is high and in_stall is low.
// Commands insert at the front, append at the back, remove at a position
// and close the gap, read at a position, or overwrite at a position.
// Output channel: each item gives one result of read_value, length and
// status, held while out_stall is high.
// A full store or a position not below the length gives an error status
// and leaves the contents unchanged.
// From acceptance to out_valid: the input register takes the item, and
// once the result register is free, the store update and the result
// register load together.
// Throughput is one item per cycle while the receiver does not stall; the
// register array shifts in parallel. When the receiver stalls, the result
// register holds, the input register fills, and then in_stall rises.
// Reset empties the store and drops both stages; entry contents are not
// cleared and need no clearing pass.
module indexed_sequence_store_unit
    import iss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic [POS_W-1:0]         position,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [VAL_W-1:0]  read_value,
    output logic [LEN_W-1:0]         length,
    output logic [STAT_W-1:0]        status
);

    logic                    s1_valid_reg;
    logic [CMD_W-1:0]        s1_cmd_reg;
    logic [POS_W-1:0]        s1_pos_reg;
    logic signed [VAL_W-1:0] s1_val_reg;
    logic                    out_valid_reg;
    iss_rsp_t                out_reg;
    logic                    advance;
    logic                    accept;
    iss_req_t                req;
    iss_rsp_t                rsp;

    // The input stage moves on when the result register is free.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept || advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= command;
            s1_pos_reg <= position;
            s1_val_reg <= value;
        end
    end

    // Command into the store.
    assign req.fire     = advance;
    assign req.op       = command_t'(s1_cmd_reg);
    assign req.position = s1_pos_reg;
    assign req.value    = s1_val_reg;

    iss_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance || !out_stall)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_reg.read_value;
    assign length     = out_reg.length;
    assign status     = out_reg.status;

    // A result waiting under stall is not overwritten.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("result overwritten while stalled");

    // An accepted item reaches the store on the next edge when the output is free.
    a_pass_on: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !(out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("accepted item lost");

    // The input side stalls only while the input register holds an item.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("stall without a held item");

endmodule

/* tb/testbench.sv */
module testbench;

    import iss_pkg::*;

    // Command codes that the store leaves unused.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_ONES = '1;
    localparam logic signed [VAL_W-1:0] VAL_FIVES = 32'sh5555_5555;
    localparam logic signed [VAL_W-1:0] VAL_TENS  = 32'shAAAA_AAAA;

    localparam int RANDOM_ITEMS   = 700;
    localparam int IDLE_PERCENT   = 7;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_ROWS       = 25;

    // One row of the directed stimulus; want is used only where typed is set.
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  val;
        int                       reps;
        bit                       typed;
        iss_rsp_t                 want;
    } stim_row_t;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // Empty store: every indexed command is out of range.
        '{CMD_READ_AT,      4'd0,  VAL_ONES,  1, 1'b1, '{'0, 5'd0, STATUS_BAD_POS}},
        '{CMD_REMOVE_AT,    4'd0,  VAL_ONES,  1, 1'b1, '{'0, 5'd0, STATUS_BAD_POS}},
        '{CMD_WRITE_AT,     4'd15, VAL_MAX,   1, 1'b1, '{'0, 5'd0, STATUS_BAD_POS}},
        // Unused codes do nothing.
        '{CMD_SPARE_FIRST,  4'd7,  VAL_ONES,  1, 1'b1, '{'0, 5'd0, STATUS_OK}},
        '{CMD_SPARE_MID,    4'd15, VAL_MIN,   1, 1'b1, '{'0, 5'd0, STATUS_OK}},
        '{CMD_SPARE_LAST,   4'd0,  VAL_MAX,   1, 1'b1, '{'0, 5'd0, STATUS_OK}},
        // Value extremes at both ends.
        '{CMD_INSERT_FRONT, 4'd0,  VAL_MIN,   1, 1'b1, '{'0, 5'd1, STATUS_OK}},
        '{CMD_APPEND_BACK,  4'd0,  VAL_MAX,   1, 1'b1, '{'0, 5'd2, STATUS_OK}},
        '{CMD_READ_AT,      4'd0,  '0,        1, 1'b1, '{VAL_MIN, 5'd2, STATUS_OK}},
        '{CMD_READ_AT,      4'd1,  '0,        1, 1'b1, '{VAL_MAX, 5'd2, STATUS_OK}},
        '{CMD_READ_AT,      4'd2,  '0,        1, 1'b1, '{'0, 5'd2, STATUS_BAD_POS}},
        '{CMD_INSERT_FRONT, 4'd9,  '0,        1, 1'b0, '0},
        '{CMD_WRITE_AT,     4'd1,  VAL_ONES,  1, 1'b1, '{'0, 5'd3, STATUS_OK}},
        '{CMD_READ_AT,      4'd1,  '0,        1, 1'b1, '{VAL_ONES, 5'd3, STATUS_OK}},
        '{CMD_REMOVE_AT,    4'd0,  '0,        1, 1'b1, '{'0, 5'd2, STATUS_OK}},
        // Fill to capacity, then both growing commands must be refused.
        '{CMD_APPEND_BACK,  4'd3,  VAL_FIVES, 14, 1'b0, '0},
        '{CMD_INSERT_FRONT, 4'd0,  VAL_TENS,  1, 1'b1, '{'0, 5'd16, STATUS_FULL}},
        '{CMD_APPEND_BACK,  4'd0,  VAL_TENS,  1, 1'b1, '{'0, 5'd16, STATUS_FULL}},
        '{CMD_READ_AT,      4'd15, '0,        1, 1'b1, '{VAL_FIVES, 5'd16, STATUS_OK}},
        '{CMD_WRITE_AT,     4'd15, VAL_TENS,  1, 1'b0, '0},
        '{CMD_READ_AT,      4'd15, '0,        1, 1'b0, '0},
        '{CMD_REMOVE_AT,    4'd15, '0,        1, 1'b1, '{'0, 5'd15, STATUS_OK}},
        '{CMD_READ_AT,      4'd15, '0,        1, 1'b1, '{'0, 5'd15, STATUS_BAD_POS}},
        '{CMD_REMOVE_AT,    4'd0,  '0,        1, 1'b0, '0},
        '{CMD_READ_AT,      4'd0,  '0,        1, 1'b0, '0}
    };

    bit                       clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [VAL_W-1:0]  read_value;
    logic [LEN_W-1:0]         length;
    logic [STAT_W-1:0]        status;

    // Shadow copy of the sequence.
    logic signed [VAL_W-1:0]  shadow_seq [CAPACITY_DEF];
    int                       shadow_len;

    iss_rsp_t                 pending_results [$];
    bit                       row_has_expect;
    iss_rsp_t                 row_expect;
    bit                       steady;
    int                       error_count;
    int                       idle_cycles;

    indexed_sequence_store_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .length     (length),
        .status     (status)
    );

    // Clock with a period of 8.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Apply one command to the shadow sequence and return what it must answer.
    function automatic iss_rsp_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [POS_W-1:0] pos,
                                               input logic signed [VAL_W-1:0] val);
        iss_rsp_t res;
        bit       in_range;
        int       k;
        res.read_value = '0;
        res.status = STATUS_OK;
        in_range = int'(pos) < shadow_len;
        case (cmd)
            CMD_INSERT_FRONT:
            begin
                if (shadow_len >= CAPACITY_DEF)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    for (k = shadow_len; k > 0; k--)
                    begin
                        shadow_seq[k] = shadow_seq[k-1];
                    end
                    shadow_seq[0] = val;
                    shadow_len++;
                end
            end
            CMD_APPEND_BACK:
            begin
                if (shadow_len >= CAPACITY_DEF)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    shadow_seq[shadow_len] = val;
                    shadow_len++;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (!in_range)
                begin
                    res.status = STATUS_BAD_POS;
                end
                else
                begin
                    for (k = int'(pos); k + 1 < shadow_len; k++)
                    begin
                        shadow_seq[k] = shadow_seq[k+1];
                    end
                    shadow_len--;
                end
            end
            CMD_READ_AT:
            begin
                if (!in_range)
                begin
                    res.status = STATUS_BAD_POS;
                end
                else
                begin
                    res.read_value = shadow_seq[pos];
                end
            end
            CMD_WRITE_AT:
            begin
                if (!in_range)
                begin
                    res.status = STATUS_BAD_POS;
                end
                else
                begin
                    shadow_seq[pos] = val;
                end
            end
            default:
            begin
            end
        endcase
        res.length = LEN_W'(shadow_len);
        return res;
    endfunction

    // Count a failure and show the first few of them.
    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // Offer one item after a random gap, none in the steady stretch, and hold it until it is taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val,
                             input bit typed,
                             input iss_rsp_t want);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        position <= pos;
        value <= val;
        row_has_expect = typed;
        row_expect = want;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // The receiver stalls at random outside the steady stretch.
    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Predict each accepted item and check each accepted result.
    always @(posedge clk)
    begin : track
        iss_rsp_t predicted;
        iss_rsp_t want;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                predicted = apply_command(command, position, value);
                pending_results.push_back(row_has_expect ? row_expect : predicted);
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                if (pending_results.size() == 0)
                begin
                    note_error($sformatf("unexpected result: value=%0d length=%0d status=%0d",
                                         read_value, length, status));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_value !== want.read_value || length !== want.length ||
                        status !== want.status)
                    begin
                        note_error($sformatf({"mismatch: expected value=%0d length=%0d ",
                                              "status=%0d, got value=%0d length=%0d status=%0d"},
                                             want.read_value, want.length, want.status,
                                             read_value, length, status));
                    end
                end
            end
        end
    end

    // Stop a run in which nothing moves for too long.
    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("testbench: done, errors");
        $finish;
    end

    // Reset, directed table, random commands, then drain.
    initial
    begin : stimulus
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  val;
        bit                       growing;
        int                       issued;
        int                       pick;
        int                       row;
        int                       rep;

        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        position = '0;
        value = '0;
        out_stall = 1'b0;
        row_has_expect = 1'b0;
        row_expect = '0;
        steady = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        shadow_len = 0;
        foreach (shadow_seq[k])
        begin
            shadow_seq[k] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        for (row = 0; row < NUM_ROWS; row++)
        begin
            for (rep = 0; rep < directed_rows[row].reps; rep++)
            begin
                send_item(directed_rows[row].cmd, directed_rows[row].pos,
                          directed_rows[row].val, directed_rows[row].typed,
                          directed_rows[row].want);
            end
        end

        // Random commands: the length sweeps between empty and full, and
        // most positions fall inside the sequence.
        growing = 1'b1;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            steady = (issued >= 250 && issued < 420);
            if (shadow_len >= CAPACITY_DEF)
            begin
                growing = 1'b0;
            end
            else if (shadow_len == 0)
            begin
                growing = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                cmd = CMD_W'($urandom_range(int'(CMD_SPARE_LAST), int'(CMD_SPARE_FIRST)));
            end
            else if (pick < 50)
            begin
                if (growing == (pick < 40))
                begin
                    cmd = $urandom_range(1) ? CMD_INSERT_FRONT : CMD_APPEND_BACK;
                end
                else
                begin
                    cmd = CMD_REMOVE_AT;
                end
            end
            else if (pick < 75)
            begin
                cmd = CMD_READ_AT;
            end
            else
            begin
                cmd = CMD_WRITE_AT;
            end
            if (shadow_len > 0 && $urandom_range(99) < 85)
            begin
                pos = POS_W'($urandom_range(shadow_len - 1));
            end
            else
            begin
                pos = POS_W'($urandom);
            end
            case ($urandom_range(19))
                0: val = VAL_MIN;
                1: val = VAL_MAX;
                2: val = '0;
                3: val = VAL_ONES;
                default: val = $urandom;
            endcase
            send_item(cmd, pos, val, 1'b0, '0);
            if (cmd < CMD_SPARE_FIRST)
            begin
                issued++;
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Wait for every result, then keep watching for strays before the verdict.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

/* indexed_sequence_store_unit.f */
hw/rtl/iss_pkg.sv
hw/rtl/iss_store.sv
hw/rtl/indexed_sequence_store_unit.sv
tb/testbench.sv
